// ===== design/psd_pkg.sv =====
// Package for the path segment subdivider: sequencer states, register map
// and fixed widths. No dependencies.
`timescale 1ns / 1ps
package psd_pkg;

  // Register selects: the value of paddr bit 2 for each register.
  localparam int unsigned PADDR_W       = 3;
  localparam logic        REG_MODE      = 1'b0;
  localparam logic        REG_DEF_ALPHA = 1'b1;

  // Subdivision modes.
  localparam logic MODE_COUNT = 1'b0;
  localparam logic MODE_DIST  = 1'b1;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_SUBDIV_DEF = 63;
  localparam int unsigned FRAC_BITS_DEF  = 8;

  // Fixed widths of the datapath.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned AMT_W   = 31;
  localparam int unsigned DIST_W  = 33;
  localparam int unsigned SQ_W    = 68;
  localparam int unsigned REM_W   = 34;

  // One-hot sequencer states.
  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_SQMUL = 11'b000_0000_0010,
    ST_SQACC = 11'b000_0000_0100,
    ST_SQRT  = 11'b000_0000_1000,
    ST_NDIV  = 11'b000_0001_0000,
    ST_NMUL  = 11'b000_0010_0000,
    ST_NOFF  = 11'b000_0100_0000,
    ST_FRAC  = 11'b000_1000_0000,
    ST_PMUL  = 11'b001_0000_0000,
    ST_PACC  = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

endpackage

// ===== design/path_segment_subdivider.sv =====
// Top level of the path segment subdivider: one shared multiplier and one
// shift-subtract unit under a one-hot sequencer. Depends on psd_pkg.
`timescale 1ns / 1ps
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   start, end, amount, segment_enabled
//  out      output     out_valid / out_ready pos, alpha, is_subpoint, last
//  cfg      input      psel/penable/pwrite   paddr, pwdata, prdata (pready high)
//
// An item is accepted in idle, then goes through squaring and summing of the
// three deltas, a shift-subtract square root, in distance mode a division for
// the spacing count, and an output state; then each subpoint takes a fraction
// division, a multiply and add per axis and an output state. The shift-subtract
// unit and the 32x32 multiplier carry out these steps.
// Reset is synchronous and active low; it clears the sequencer, the configuration registers and the output valid.
// in_ready is high only when idle; a stalled result holds the sequencer.
module path_segment_subdivider #(
  parameter int unsigned MAX_SUBDIV = psd_pkg::MAX_SUBDIV_DEF,
  parameter int unsigned FRAC_BITS  = psd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                in_start_x,
  input  logic signed [31:0]                in_start_y,
  input  logic signed [31:0]                in_start_z,
  input  logic signed [31:0]                in_end_x,
  input  logic signed [31:0]                in_end_y,
  input  logic signed [31:0]                in_end_z,
  input  logic [30:0]                       in_amount,
  input  logic                              in_segment_enabled,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_pos_x,
  output logic signed [31:0]                out_pos_y,
  output logic signed [31:0]                out_pos_z,
  output logic [15:0]                       out_alpha,
  output logic                              out_is_subpoint,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psd_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import psd_pkg::*;

  localparam int unsigned NW = $clog2(MAX_SUBDIV + 1);
  localparam logic [NW-1:0] NMAX = NW'(MAX_SUBDIV);

  state_t state_r, state_nxt;

  // Configuration registers.
  logic        mode_r;
  logic [15:0] def_alpha_r;

  // Latched item.
  logic signed [COORD_W-1:0] st_r [3];
  logic [COORD_W-1:0]        mag_r [3];
  logic [2:0]                neg_r;
  logic [AMT_W-1:0]          amt_r;
  logic                      en_r;
  logic                      imode_r;

  // Shared datapath registers.
  logic [63:0]       prod_r;
  logic [SQ_W-1:0]   sum_r, res_r, one_r;
  logic [DIST_W-1:0] dist_r, num_r, div_r;
  logic [REM_W-1:0]  rem_r, t_r;
  logic [31:0]       f_r;
  logic [NW-1:0]     n_r, s_r;
  logic [5:0]        cnt_r;
  logic [1:0]        ax_r;

  // Output registers.
  logic signed [COORD_W-1:0] pos_r [3];
  logic [15:0] alpha_r;
  logic        sub_r, last_r, ov_r;

  // Combinational helpers.
  logic [31:0]       mul_a, mul_b;
  logic [SQ_W-1:0]   trial, res_nxt;
  logic              sq_ge;
  logic [REM_W-1:0]  rem_sh, fr_sh;
  logic [DIST_W-1:0] amt_ext;
  logic [NW-1:0]     cnt_n, q_n;
  logic [AMT_W-1:0]  amt_int;
  logic [64:0]       rnd;
  logic [32:0]       q_pl;
  logic [32:0]       pos_sum;
  logic              in_acc, out_acc, cfg_wr;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = ov_r && out_ready;
  assign cfg_wr  = psel && penable && pwrite && pready;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = ov_r;
  assign out_pos_x       = pos_r[0];
  assign out_pos_y       = pos_r[1];
  assign out_pos_z       = pos_r[2];
  assign out_alpha       = alpha_r;
  assign out_is_subpoint = sub_r;
  assign out_last        = last_r;
  assign pready          = 1'b1;
  assign prdata = (paddr[2] == REG_DEF_ALPHA) ? {16'd0, def_alpha_r} : {31'd0, mode_r};

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = mag_r[ax_r];
    mul_b = mag_r[ax_r];
    case (state_r)
      ST_NMUL: begin
        mul_a = 32'(q_n);
        mul_b = {1'b0, amt_r};
      end
      ST_PMUL: mul_b = f_r;
      default: ;
    endcase
  end

  // Square root step, shift-subtract steps, counts and rounding.
  assign trial   = res_r + one_r;
  assign sq_ge   = sum_r >= trial;
  assign res_nxt = sq_ge ? ((res_r >> 1) + one_r) : (res_r >> 1);
  assign amt_ext = {2'd0, amt_r};
  assign rem_sh  = {rem_r[REM_W-2:0], num_r[DIST_W-1]};
  assign fr_sh   = {rem_r[REM_W-2:0], 1'b0};
  assign amt_int = amt_r >> FRAC_BITS;
  assign cnt_n   = (amt_int > AMT_W'(MAX_SUBDIV)) ? NMAX : amt_int[NW-1:0];
  assign q_n     = (num_r > DIST_W'(MAX_SUBDIV)) ? NMAX : num_r[NW-1:0];
  assign rnd     = {1'b0, prod_r} + 65'h0_8000_0000;
  assign q_pl    = rnd[64:32];
  assign pos_sum = neg_r[ax_r] ? ({st_r[ax_r][31], st_r[ax_r]} - q_pl)
                               : ({st_r[ax_r][31], st_r[ax_r]} + q_pl);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SQMUL;
      ST_SQMUL: state_nxt = ST_SQACC;
      ST_SQACC: state_nxt = (ax_r == 2'd2) ? ST_SQRT : ST_SQMUL;
      ST_SQRT: begin
        if (one_r[0]) begin
          if (en_r && imode_r == MODE_DIST && amt_r != '0) state_nxt = ST_NDIV;
          else state_nxt = ST_OUT;
        end
      end
      ST_NDIV:  if (cnt_r == 6'd1) state_nxt = ST_NMUL;
      ST_NMUL:  state_nxt = ST_NOFF;
      ST_NOFF:  state_nxt = ST_OUT;
      ST_FRAC:  if (cnt_r == 6'd1) state_nxt = ST_PMUL;
      ST_PMUL:  state_nxt = ST_PACC;
      ST_PACC:  state_nxt = (ax_r == 2'd2) ? ST_OUT : ST_PMUL;
      ST_OUT: begin
        if (out_ready) state_nxt = last_r ? ST_IDLE : ST_FRAC;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_COUNT;
      def_alpha_r <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_MODE) mode_r <= pwdata[0];
        else def_alpha_r <= pwdata[15:0];
      end
      if (out_acc) ov_r <= 1'b0;
      else if (state_r != ST_OUT && state_nxt == ST_OUT) ov_r <= 1'b1;
    end
  end

  // Sign and magnitude of a 33-bit difference.
  function automatic logic [32:0] abs33(input logic [32:0] v);
    logic [32:0] m;
    m = v[32] ? (~v + 33'd1) : v;
    return {v[32], m[31:0]};
  endfunction

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_r[0] <= in_start_x;
          st_r[1] <= in_start_y;
          st_r[2] <= in_start_z;
          {neg_r[0], mag_r[0]} <= abs33({in_end_x[31], in_end_x} - {in_start_x[31], in_start_x});
          {neg_r[1], mag_r[1]} <= abs33({in_end_y[31], in_end_y} - {in_start_y[31], in_start_y});
          {neg_r[2], mag_r[2]} <= abs33({in_end_z[31], in_end_z} - {in_start_z[31], in_start_z});
          amt_r   <= in_amount;
          en_r    <= in_segment_enabled;
          imode_r <= mode_r;
          sum_r   <= '0;
          res_r   <= '0;
          one_r   <= SQ_W'(1) << 66;
          ax_r    <= 2'd0;
        end
      end
      ST_SQMUL: prod_r <= mul_a * mul_b;
      ST_SQACC: begin
        sum_r <= sum_r + SQ_W'(prod_r);
        ax_r  <= ax_r + 2'd1;
      end
      ST_SQRT: begin
        if (sq_ge) sum_r <= sum_r - trial;
        res_r <= res_nxt;
        one_r <= one_r >> 2;
        if (one_r[0]) begin
          dist_r  <= res_nxt[DIST_W-1:0];
          num_r   <= res_nxt[DIST_W-1:0];
          rem_r   <= '0;
          cnt_r   <= 6'(DIST_W);
          n_r     <= (en_r && imode_r == MODE_COUNT) ? cnt_n : '0;
          s_r     <= '0;
          // Start point of the segment.
          pos_r   <= st_r;
          alpha_r <= def_alpha_r;
          sub_r   <= 1'b0;
          last_r  <= !(en_r && ((imode_r == MODE_COUNT) ? (cnt_n != '0) : (amt_r != '0)));
        end
      end
      ST_NDIV: begin
        // One quotient bit of dist / amount per cycle.
        if (rem_sh >= REM_W'(amt_ext)) begin
          rem_r <= rem_sh - REM_W'(amt_ext);
          num_r <= {num_r[DIST_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          num_r <= {num_r[DIST_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
      end
      ST_NMUL: begin
        n_r    <= q_n;
        last_r <= (q_n == '0);
      end
      ST_NOFF: begin
        prod_r <= prod_r;
        t_r    <= REM_W'((dist_r - prod_r[DIST_W-1:0]) >> 1);
      end
      ST_FRAC: begin
        // One bit of floor(2^32 t / d) per cycle.
        if (fr_sh >= REM_W'(div_r)) begin
          rem_r <= fr_sh - REM_W'(div_r);
          f_r   <= {f_r[30:0], 1'b1};
        end else begin
          rem_r <= fr_sh;
          f_r   <= {f_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        ax_r  <= 2'd0;
      end
      ST_PMUL: prod_r <= mul_a * mul_b;
      ST_PACC: begin
        pos_r[ax_r] <= pos_sum[31:0];
        ax_r        <= ax_r + 2'd1;
        alpha_r     <= f_r[31:16];
        sub_r       <= 1'b1;
        last_r      <= (REM_W'(s_r) + REM_W'(1) == REM_W'(n_r));
      end
      ST_OUT: begin
        if (out_ready && !last_r) begin
          // Set up the fraction division for the next subpoint.
          cnt_r <= 6'd32;
          f_r   <= '0;
          if (imode_r == MODE_COUNT) begin
            rem_r <= REM_W'(s_r) + REM_W'(1);
            div_r <= DIST_W'(n_r) + DIST_W'(1);
          end else begin
            rem_r <= t_r;
            div_r <= dist_r;
          end
          if (sub_r) begin
            s_r <= s_r + NW'(1);
            if (imode_r == MODE_COUNT) rem_r <= REM_W'(s_r) + REM_W'(2);
            else rem_r <= t_r + REM_W'(amt_r);
            t_r <= t_r + REM_W'(amt_r);
          end
        end
      end
      default: ;
    endcase
    if (state_r == ST_NMUL) prod_r <= mul_a * mul_b;
  end

  // No result is pending whenever a new item may enter.
  a_ready_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("in_ready with a pending result");

  // An accepted item moves the block out of idle.
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready) else $error("still ready after accept");

  // Delivering the final result returns to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last) |=> in_ready) else $error("not idle after last item");

  // A start point always carries the default alpha.
  a_start_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_subpoint) |-> (out_alpha == def_alpha_r))
    else $error("start point alpha differs from default");

endmodule

// ===== tb/path_segment_subdivider_tb.sv =====
// Self-checking testbench for path_segment_subdivider: directed and random segments
// checked against a predictor of the subdivision arithmetic.
// Depends on psd_pkg and the path_segment_subdivider RTL.
`timescale 1ns / 1ps
module path_segment_subdivider_tb;
  import psd_pkg::*;

  typedef struct packed {
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic [30:0]        amount;
    logic               enabled;
  } segment_t;

  typedef struct packed {
    logic [31:0] pos_x, pos_y, pos_z;
    logic [15:0] alpha;
    logic        is_subpoint;
    logic        last;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_start_x = '0, in_start_y = '0, in_start_z = '0;
  logic signed [31:0] in_end_x = '0, in_end_y = '0, in_end_z = '0;
  logic [30:0] in_amount = '0;
  logic in_segment_enabled = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic [15:0] out_alpha;
  logic out_is_subpoint, out_last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Register copies held by the predictor.
  logic        cur_mode = MODE_COUNT;
  logic [15:0] cur_def_alpha = '0;

  point_t expected_points[$];
  int     errors = 0;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  int     rx_hold_cycles = 0;

  path_segment_subdivider dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

  // Floor square root of the squared length, digit by digit.
  function automatic logic [32:0] seg_length(logic [67:0] op);
    logic [67:0] res, one, trial;
    res = '0;
    one = 68'd1 << 66;
    while (one != 0) begin
      trial = res + one;
      if (op >= trial) begin
        op = op - trial;
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res[32:0];
  endfunction

  // Start plus the rounded fraction of the delta, half away from zero.
  function automatic logic [31:0] place_coord(logic signed [33:0] st,
                                              logic signed [33:0] d, logic [31:0] f);
    logic [33:0] mag;
    logic [67:0] prod;
    logic [33:0] q;
    logic signed [33:0] r;
    mag = d < 0 ? -d : d;
    prod = 68'(mag) * 68'(f) + 68'h8000_0000;
    q = 34'(prod >> 32);
    r = d < 0 ? st - $signed(q) : st + $signed(q);
    return r[31:0];
  endfunction

  // Works out every point that one segment yields under the current registers.
  task automatic subdivide_segment(segment_t sg);
    logic signed [33:0] st[3], dl[3];
    logic [33:0] mag;
    logic [67:0] sq_sum;
    logic [32:0] seg_len;
    logic [63:0] n, offset, t;
    logic [95:0] num;
    logic [31:0] f;
    point_t p;
    sq_sum = '0;
    st[0] = sg.sx; st[1] = sg.sy; st[2] = sg.sz;
    dl[0] = 34'(sg.ex) - st[0];
    dl[1] = 34'(sg.ey) - st[1];
    dl[2] = 34'(sg.ez) - st[2];
    for (int k = 0; k < 3; k++) begin
      mag = dl[k] < 0 ? -dl[k] : dl[k];
      sq_sum += 68'(mag) * 68'(mag);
    end
    seg_len = seg_length(sq_sum);
    n = 0;
    offset = 0;
    if (sg.enabled) begin
      if (cur_mode == MODE_COUNT) n = 64'(sg.amount) >> FRAC_BITS_DEF;
      else if (sg.amount != 0) n = 64'(seg_len) / 64'(sg.amount);
      if (n > MAX_SUBDIV_DEF) n = MAX_SUBDIV_DEF;
      if (cur_mode == MODE_DIST) offset = (64'(seg_len) - n * 64'(sg.amount)) >> 1;
    end
    p.pos_x = sg.sx; p.pos_y = sg.sy; p.pos_z = sg.sz;
    p.alpha = cur_def_alpha;
    p.is_subpoint = 1'b0;
    p.last = (n == 0);
    expected_points.push_back(p);
    for (longint s = 0; s < n; s++) begin
      if (cur_mode == MODE_COUNT) begin
        f = 32'((64'(s + 1) << 32) / (n + 1));
      end else begin
        t = offset + 64'(s) * 64'(sg.amount);
        num = 96'(t) << 32;
        f = 32'(num / 96'(seg_len));
      end
      p.pos_x = place_coord(st[0], dl[0], f);
      p.pos_y = place_coord(st[1], dl[1], f);
      p.pos_z = place_coord(st[2], dl[2], f);
      p.alpha = f[31:16];
      p.is_subpoint = 1'b1;
      p.last = (s + 1 == n);
      expected_points.push_back(p);
    end
  endtask

  // Result checker: each accepted point against the oldest expected one.
  always @(posedge clk) begin
    point_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected point x=%h y=%h z=%h", out_pos_x, out_pos_y, out_pos_z);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (out_pos_x !== e.pos_x) begin
          $error("pos_x expected %h got %h", e.pos_x, out_pos_x); errors++;
        end
        if (out_pos_y !== e.pos_y) begin
          $error("pos_y expected %h got %h", e.pos_y, out_pos_y); errors++;
        end
        if (out_pos_z !== e.pos_z) begin
          $error("pos_z expected %h got %h", e.pos_z, out_pos_z); errors++;
        end
        if (out_alpha !== e.alpha) begin
          $error("alpha expected %h got %h", e.alpha, out_alpha); errors++;
        end
        if (out_is_subpoint !== e.is_subpoint) begin
          $error("is_subpoint expected %b got %b", e.is_subpoint, out_is_subpoint);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last expected %b got %b", e.last, out_last); errors++;
        end
      end
    end
  end

  // Result-side readiness: a long hold-off when requested, else random stalls.
  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_ready <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offers one segment and waits for it to be taken; called at a rising edge.
  task automatic send_segment(segment_t sg);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_start_x <= sg.sx; in_start_y <= sg.sy; in_start_z <= sg.sz;
    in_end_x <= sg.ex; in_end_y <= sg.ey; in_end_z <= sg.ez;
    in_amount <= sg.amount;
    in_segment_enabled <= sg.enabled;
    do @(posedge clk); while (!in_ready);
    subdivide_segment(sg);
  endtask

  // Drops valid and waits until every expected point has come out.
  task automatic drain_points();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic mode, logic [15:0] def_alpha);
    drain_points();
    write_reg(PADDR_W'({REG_MODE, 2'b00}), 32'(mode));
    write_reg(PADDR_W'({REG_DEF_ALPHA, 2'b00}), 32'(def_alpha));
    cur_mode = mode;
    cur_def_alpha = def_alpha;
  endtask

  function automatic segment_t make_segment(logic signed [31:0] sx, sy, sz, ex, ey, ez,
                                            logic [30:0] amount, logic enabled);
    segment_t sg;
    sg.sx = sx; sg.sy = sy; sg.sz = sz; sg.ex = ex; sg.ey = ey; sg.ez = ez;
    sg.amount = amount;
    sg.enabled = enabled;
    return sg;
  endfunction

  // Random segment: full-range or local geometry, amount sized for a modest count.
  function automatic segment_t random_segment();
    segment_t sg;
    int span_bits;
    sg.sx = $urandom; sg.sy = $urandom; sg.sz = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      sg.ex = $urandom; sg.ey = $urandom; sg.ez = $urandom;
      span_bits = 32;
    end else begin
      span_bits = $urandom_range(0, 24);
      sg.ex = sg.sx + $signed($urandom_range(0, (1 << span_bits) - 1)) - (1 << span_bits) / 2;
      sg.ey = sg.sy + $signed($urandom_range(0, (1 << span_bits) - 1)) - (1 << span_bits) / 2;
      sg.ez = sg.sz + $signed($urandom_range(0, (1 << span_bits) - 1)) - (1 << span_bits) / 2;
    end
    if ($urandom_range(0, 19) == 0) begin
      sg.amount = 31'($urandom);
    end else if (cur_mode == MODE_COUNT) begin
      sg.amount = 31'(($urandom_range(0, 8) << FRAC_BITS_DEF) | $urandom_range(0, 255));
    end else begin
      sg.amount = 31'($urandom_range(1, 31'h7FFF_FFFF >> (31 - (span_bits > 30 ? 30 : span_bits))));
      sg.amount = sg.amount | 31'(span_bits >= 3 ? (1 << (span_bits - 3)) : 1);
    end
    sg.enabled = ($urandom_range(0, 9) != 0);
    return sg;
  endfunction

  task automatic test_count_directed();
    set_config(MODE_COUNT, 16'h0000);
    send_segment(make_segment(0, 0, 0, 32'sh1000, 32'sh2000, -32'sh300, 31'h000, 1'b1));
    send_segment(make_segment(0, 0, 0, 32'sh1000, 0, 0, 31'h100, 1'b1));
    send_segment(make_segment(0, 0, 0, 32'sh1000, 0, 0, 31'h3FF, 1'b1));
    send_segment(make_segment(-32'sd5, 7, 9, 100, -200, 300, 31'h500, 1'b0));
    send_segment(make_segment(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                              31'h7FFF_FFFF, 1'b1));
    send_segment(make_segment(1234, -77, 55, 1234, -77, 55, 31'h300, 1'b1));
    set_config(MODE_COUNT, 16'hFFFF);
    send_segment(make_segment(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0,
                              32'sh8000_0000, 31'h4000, 1'b1));
    send_segment(make_segment(0, 0, 0, 3, -3, 1, 31'h2FF, 1'b1));
  endtask

  task automatic test_distance_directed();
    set_config(MODE_DIST, 16'h8001);
    send_segment(make_segment(0, 0, 0, 32'sh1000, 0, 0, 31'h0, 1'b1));
    send_segment(make_segment(500, 500, 500, 500, 500, 500, 31'h10, 1'b1));
    send_segment(make_segment(0, 0, 0, 32'sh1000, 32'sh0, 0, 31'h300, 1'b1));
    send_segment(make_segment(0, 0, 0, -32'sh1000, 32'sh1000, 32'sh500, 31'h1, 1'b1));
    send_segment(make_segment(0, 0, 0, 32'sh100, 0, 0, 31'h7FFF_FFFF, 1'b1));
    send_segment(make_segment(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                              31'h4000_0000, 1'b1));
    send_segment(make_segment(10, 20, 30, 5000, -6000, 7000, 31'h200, 1'b0));
  endtask

  // Receiver holds off while segments keep coming, so the input stalls.
  task automatic test_backpressure();
    set_config(MODE_COUNT, 16'h1234);
    rx_hold_cycles = 3000;
    repeat (6) send_segment(random_segment());
  endtask

  task automatic test_random(int count, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 45 == 0) set_config(logic'($urandom_range(0, 1)), 16'($urandom));
      send_segment(random_segment());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_count_directed();
    test_distance_directed();
    test_backpressure();
    test_random(130, 23, 71);
    test_random(130, 71, 23);
    test_random(130, 0, 0);
    drain_points();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== path_segment_subdivider.f =====
design/psd_pkg.sv
design/path_segment_subdivider.sv
tb/path_segment_subdivider_tb.sv
